/* hw/rtl/pds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared command codes and status bundle for the pairwise distance sorter.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int OutD2Bits    = 34;
  localparam int OutFixBits   = 25;
  localparam int FracBits     = 16;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_BUILD_START,
    DP_BUILD_RD,
    DP_BUILD_SQ,
    DP_BUILD_WR,
    DP_SORT_START,
    DP_PASS_NEXT,
    DP_SORT_DONE,
    DP_SEG_START,
    DP_LOAD_HA,
    DP_LOAD_HB,
    DP_MERGE_EMIT,
    DP_FETCH_HEAD,
    DP_SEG_NEXT,
    DP_READ_PAIR,
    DP_READ_PTS,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_OUT_LOAD
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_last;
    logic few;
    logic build_last;
    logic w_done;
    logic s_done;
    logic merge_end;
    logic read_ok;
    logic sqrt_done;
    logic out_free;
  } pds_status_t;

endpackage

/* hw/rtl/pds_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/pds_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer for load, pair build, merge sort passes and result read-out.
// ----------------------------------------------------------------------------
module pds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  pds_pkg::pds_status_t status,
  output pds_pkg::dp_cmd_t    cmd
);
  import pds_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_CLOSE    = 16'h0002,
    ST_B_RD     = 16'h0004,
    ST_B_SQ     = 16'h0008,
    ST_B_WR     = 16'h0010,
    ST_SORT_INI = 16'h0020,
    ST_PASS_CHK = 16'h0040,
    ST_SEG_CHK  = 16'h0080,
    ST_LD_HA    = 16'h0100,
    ST_LD_HB    = 16'h0200,
    ST_MERGE    = 16'h0400,
    ST_FETCH    = 16'h0800,
    ST_R_PTS    = 16'h1000,
    ST_R_INIT   = 16'h2000,
    ST_R_SQ     = 16'h4000,
    ST_R_OUT    = 16'h8000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = DP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (status.is_read) begin
            if (status.read_ok) begin
              cmd        = DP_READ_PAIR;
              state_next = ST_R_PTS;
            end
          end else begin
            cmd = DP_LOAD;
            if (status.is_last) begin
              state_next = ST_CLOSE;
            end
          end
        end
      end
      ST_CLOSE: begin
        if (status.few) begin
          cmd        = DP_SORT_START;
          state_next = ST_PASS_CHK;
        end else begin
          cmd        = DP_BUILD_START;
          state_next = ST_B_RD;
        end
      end
      ST_B_RD: begin
        cmd        = DP_BUILD_RD;
        state_next = ST_B_SQ;
      end
      ST_B_SQ: begin
        cmd        = DP_BUILD_SQ;
        state_next = ST_B_WR;
      end
      ST_B_WR: begin
        cmd        = DP_BUILD_WR;
        state_next = status.build_last ? ST_SORT_INI : ST_B_RD;
      end
      ST_SORT_INI: begin
        cmd        = DP_SORT_START;
        state_next = ST_PASS_CHK;
      end
      ST_PASS_CHK: begin
        if (status.w_done) begin
          cmd        = DP_SORT_DONE;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SEG_CHK;
        end
      end
      ST_SEG_CHK: begin
        if (status.s_done) begin
          cmd        = DP_PASS_NEXT;
          state_next = ST_PASS_CHK;
        end else begin
          cmd        = DP_SEG_START;
          state_next = ST_LD_HA;
        end
      end
      ST_LD_HA: begin
        cmd        = DP_LOAD_HA;
        state_next = ST_LD_HB;
      end
      ST_LD_HB: begin
        cmd        = DP_LOAD_HB;
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (status.merge_end) begin
          cmd        = DP_SEG_NEXT;
          state_next = ST_SEG_CHK;
        end else begin
          cmd        = DP_MERGE_EMIT;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd        = DP_FETCH_HEAD;
        state_next = ST_MERGE;
      end
      ST_R_PTS: begin
        cmd        = DP_READ_PTS;
        state_next = ST_R_INIT;
      end
      ST_R_INIT: begin
        cmd        = DP_SQRT_INIT;
        state_next = ST_R_SQ;
      end
      ST_R_SQ: begin
        if (status.sqrt_done) begin
          state_next = ST_R_OUT;
        end else begin
          cmd = DP_SQRT_STEP;
        end
      end
      ST_R_OUT: begin
        if (status.out_free) begin
          cmd        = DP_OUT_LOAD;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/pds_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_dp
// Point and pair stores, pair distance unit, merge datapath, bit-serial
// square root and output register.
// ----------------------------------------------------------------------------
module pds_dp #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pds_pkg::dp_cmd_t     cmd,
  output pds_pkg::pds_status_t status,
  input  logic [47:0]          s_tdata,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [159:0]         m_tdata,
  output logic                 m_tlast
);
  import pds_pkg::*;

  localparam int CB       = COORD_BITS;
  localparam int PIW      = $clog2(MAX_POINTS);
  localparam int CW       = $clog2(MAX_POINTS + 1);
  localparam int PAIR_CAP = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
  localparam int PAW      = (PAIR_CAP > 1) ? $clog2(PAIR_CAP) : 1;
  localparam int PCW      = $clog2(PAIR_CAP + 1);
  localparam int SW       = PCW + 2;
  localparam int DW       = 2 * CB + 2;
  localparam int PEW      = 2 * PIW + DW;
  localparam int PTW      = 3 * CB;
  localparam int XW       = DW + FracBits;
  localparam int RW       = XW / 2;
  localparam int REMW     = RW + 3;
  localparam int SCW      = $clog2(RW + 1);

  // input fields
  logic [15:0]   in_x, in_y, in_z;
  logic [PTW-1:0] in_pt;
  assign in_x  = s_tdata[15:0];
  assign in_y  = s_tdata[31:16];
  assign in_z  = s_tdata[47:32];
  assign in_pt = {CB'(in_z), CB'(in_y), CB'(in_x)};

  // control registers
  logic [CW-1:0]  count;
  logic           phase;
  logic [PCW-1:0] rp;
  logic [PCW-1:0] k;
  logic [SW-1:0]  n, w, s, a, b, o, mid, seg_end;
  logic           sel, last_a;
  logic [PIW-1:0] i, j;
  logic [SCW-1:0] scnt;

  // payload registers
  logic [DW-1:0]   sq_x, sq_y, sq_z;
  logic [PEW-1:0]  ha, hb;
  logic [DW-1:0]   pr_d2;
  logic [PTW-1:0]  c_lo, c_hi;
  logic [XW-1:0]   xs;
  logic [RW-1:0]   root;
  logic [REMW-1:0] rem;

  // point stores
  logic [CW-1:0]  ld_base;
  logic           ld_ok;
  logic [PIW-1:0] pt_ra, pt_rb;
  logic [PTW-1:0] pt_da, pt_db;

  assign ld_base = phase ? '0 : count;
  assign ld_ok   = (ld_base < CW'(MAX_POINTS));

  // pair stores
  logic           we0, we1;
  logic [PAW-1:0] pr_wa, pr_ra;
  logic [PEW-1:0] pr_wd, pr_d0, pr_d1, pr_src;
  logic           take_a;
  logic [SW-1:0]  next_idx;
  logic [DW-1:0]  d2_sum;

  assign pr_src  = sel ? pr_d1 : pr_d0;
  assign take_a  = (a < mid) && (!(b < seg_end) || (ha[DW-1:0] >= hb[DW-1:0]));
  assign next_idx = take_a ? a + SW'(1) : b + SW'(1);
  assign d2_sum  = sq_x + sq_y + sq_z;

  always_comb begin
    unique case (cmd)
      DP_SEG_START:  pr_ra = s[PAW-1:0];
      DP_LOAD_HA:    pr_ra = mid[PAW-1:0];
      DP_MERGE_EMIT: pr_ra = next_idx[PAW-1:0];
      DP_READ_PAIR:  pr_ra = rp[PAW-1:0];
      default:       pr_ra = '0;
    endcase
  end

  always_comb begin
    unique case (cmd)
      DP_BUILD_RD: begin
        pt_ra = i;
        pt_rb = j;
      end
      DP_READ_PTS: begin
        pt_ra = pr_src[PEW-1:DW+PIW];
        pt_rb = pr_src[DW+PIW-1:DW];
      end
      default: begin
        pt_ra = '0;
        pt_rb = '0;
      end
    endcase
  end

  assign we0   = (cmd == DP_BUILD_WR) || ((cmd == DP_MERGE_EMIT) && sel);
  assign we1   = (cmd == DP_MERGE_EMIT) && !sel;
  assign pr_wa = (cmd == DP_BUILD_WR) ? k[PAW-1:0] : o[PAW-1:0];
  assign pr_wd = (cmd == DP_BUILD_WR) ? {i, j, d2_sum} : (take_a ? ha : hb);

  pds_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS), .AW(PIW)) u_pt_a (
    .clk(clk), .we(cmd == DP_LOAD && ld_ok), .waddr(ld_base[PIW-1:0]),
    .wdata(in_pt), .raddr(pt_ra), .rdata(pt_da)
  );
  pds_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS), .AW(PIW)) u_pt_b (
    .clk(clk), .we(cmd == DP_LOAD && ld_ok), .waddr(ld_base[PIW-1:0]),
    .wdata(in_pt), .raddr(pt_rb), .rdata(pt_db)
  );
  pds_ram #(.WIDTH(PEW), .DEPTH(PAIR_CAP), .AW(PAW)) u_pair0 (
    .clk(clk), .we(we0), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_d0)
  );
  pds_ram #(.WIDTH(PEW), .DEPTH(PAIR_CAP), .AW(PAW)) u_pair1 (
    .clk(clk), .we(we1), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_d1)
  );

  // coordinate differences
  logic signed [CB:0]   dx, dy, dz;
  assign dx = ($signed(pt_da[CB-1:0]))      - $signed(pt_db[CB-1:0]);
  assign dy = ($signed(pt_da[2*CB-1:CB]))   - $signed(pt_db[2*CB-1:CB]);
  assign dz = ($signed(pt_da[3*CB-1:2*CB])) - $signed(pt_db[3*CB-1:2*CB]);

  // square root step
  logic [REMW-1:0] rem_sh, trial;
  assign rem_sh = {rem[REMW-3:0], xs[XW-1:XW-2]};
  assign trial  = REMW'({root, 2'b01});

  // output formatting
  logic [RW:0]            rnd;
  logic [63:0]            d2_ext, fx_ext;
  logic signed [CB-1:0]   lx, ly, lz, hx, hy, hz;
  assign rnd    = (rem > REMW'(root)) ? (RW+1)'(root) + (RW+1)'(1) : (RW+1)'(root);
  assign d2_ext = 64'(pr_d2);
  assign fx_ext = 64'(rnd);
  assign lx = c_lo[CB-1:0];
  assign ly = c_lo[2*CB-1:CB];
  assign lz = c_lo[3*CB-1:2*CB];
  assign hx = c_hi[CB-1:0];
  assign hy = c_hi[2*CB-1:CB];
  assign hz = c_hi[3*CB-1:2*CB];

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      phase    <= 1'b0;
      rp       <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
      scnt     <= '0;
    end else begin
      if (m_tvalid && m_tready && (cmd != DP_OUT_LOAD)) begin
        m_tvalid <= 1'b0;
      end
      unique case (cmd)
        DP_LOAD: begin
          count <= ld_ok ? ld_base + CW'(1) : ld_base;
          phase <= 1'b0;
          rp    <= '0;
          k     <= '0;
        end
        DP_BUILD_START: begin
          i <= '0;
          j <= PIW'(1);
          k <= '0;
        end
        DP_BUILD_SQ: begin
          sq_x <= DW'(unsigned'(DW'(dx) * DW'(dx)));
          sq_y <= DW'(unsigned'(DW'(dy) * DW'(dy)));
          sq_z <= DW'(unsigned'(DW'(dz) * DW'(dz)));
        end
        DP_BUILD_WR: begin
          k <= k + PCW'(1);
          if (CW'(j) == count - CW'(1)) begin
            i <= i + PIW'(1);
            j <= i + PIW'(2);
          end else begin
            j <= j + PIW'(1);
          end
        end
        DP_SORT_START: begin
          n   <= SW'(k);
          w   <= SW'(1);
          s   <= '0;
          sel <= 1'b0;
        end
        DP_PASS_NEXT: begin
          w   <= w << 1;
          s   <= '0;
          sel <= ~sel;
        end
        DP_SORT_DONE: begin
          phase <= 1'b1;
          rp    <= '0;
        end
        DP_SEG_START: begin
          a       <= s;
          o       <= s;
          b       <= (s + w < n) ? s + w : n;
          mid     <= (s + w < n) ? s + w : n;
          seg_end <= (s + (w << 1) < n) ? s + (w << 1) : n;
        end
        DP_LOAD_HA: ha <= pr_src;
        DP_LOAD_HB: hb <= pr_src;
        DP_MERGE_EMIT: begin
          o      <= o + SW'(1);
          last_a <= take_a;
          if (take_a) begin
            a <= a + SW'(1);
          end else begin
            b <= b + SW'(1);
          end
        end
        DP_FETCH_HEAD: begin
          if (last_a) begin
            ha <= pr_src;
          end else begin
            hb <= pr_src;
          end
        end
        DP_SEG_NEXT: s <= s + (w << 1);
        DP_READ_PTS: pr_d2 <= pr_src[DW-1:0];
        DP_SQRT_INIT: begin
          c_lo <= pt_da;
          c_hi <= pt_db;
          xs   <= {pr_d2, FracBits'(0)};
          root <= '0;
          rem  <= '0;
          scnt <= SCW'(RW);
        end
        DP_SQRT_STEP: begin
          xs   <= xs << 2;
          scnt <= scnt - SCW'(1);
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[RW-2:0], 1'b0};
          end
        end
        DP_OUT_LOAD: begin
          m_tvalid <= 1'b1;
          m_tlast  <= (rp + PCW'(1) == n[PCW-1:0]);
          m_tdata  <= {5'b0, fx_ext[OutFixBits-1:0], d2_ext[OutD2Bits-1:0],
                       16'(hz), 16'(hy), 16'(hx), 16'(lz), 16'(ly), 16'(lx)};
          rp       <= rp + PCW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign status.is_read    = s_tuser;
  assign status.is_last    = s_tlast;
  assign status.few        = (count < CW'(2));
  assign status.build_last = (CW'(i) == count - CW'(2)) && (CW'(j) == count - CW'(1));
  assign status.w_done     = (w >= n);
  assign status.s_done     = (s >= n);
  assign status.merge_end  = !(a < mid) && !(b < seg_end);
  assign status.read_ok    = phase && (SW'(rp) < n);
  assign status.sqrt_done  = (scnt == '0);
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

/* hw/rtl/pairwise_distance_sorter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_distance_sorter_unit
// Loads 3-D points, builds all point pairs, merge-sorts them by squared
// distance (largest first, stable) and streams the sorted pairs on request.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser = 0 loads one point, tuser = 1 requests the next
// sorted pair; tlast on a load closes the set. The closing load starts the
// pair build (read, square and write states for each pair) and the merge
// sort (ceil(log2(pairs)) passes); s_tready is low for that whole time.
// A read producing a result runs the bit-serial square root that forms
// dist_fixed; a read with nothing left is taken and returns nothing.
// Results leave through an output register on m_*, tlast marking the final
// pair. While the receiver stalls the register holds its transfer; further
// loads are still taken, a further read waits at the end of its work until
// the register is free.
// Reset returns the block to an empty set with no pending result.
// ----------------------------------------------------------------------------
module pairwise_distance_sorter_unit #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // x_coord, y_coord, z_coord
  input  logic         s_tuser,   // cmd
  input  logic         s_tlast,   // last_point
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // first_x/y/z, second_x/y/z, dist_squared,
                                  // dist_fixed, zero fill
  output logic         m_tlast    // last_pair
);
  import pds_pkg::*;

  dp_cmd_t     cmd;
  pds_status_t status;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pds_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
